// File: rtl/core/psg_pkg.sv
package psg_pkg;

	// Default table capacity
	localparam int unsigned DEPTH_DEF = 64;

	// Fixed field widths
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned TICKS_W = 32;
	localparam int unsigned IDX_W   = 11;
	localparam int unsigned LEN_W   = 7;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 3'd0,
		CMD_ADD   = 3'd1,
		CMD_START = 3'd2,
		CMD_TICK  = 3'd3,
		CMD_READ  = 3'd4
	} psg_cmd_t;

	// One table entry: output level and its duration in ticks
	typedef struct packed {
		logic               level;
		logic [TICKS_W-1:0] ticks;
	} psg_entry_t;

endpackage

// File: rtl/core/psg_table.sv
module psg_table #(
	parameter int unsigned DEPTH = psg_pkg::DEPTH_DEF,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  psg_pkg::psg_entry_t wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output psg_pkg::psg_entry_t rdata
);
	import psg_pkg::*;

	psg_entry_t mem [DEPTH];
	psg_entry_t rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/pulse_sequence_generator_unit.sv
// Pulse sequence generator: plays a table of (level, duration) steps on one output.
// A command is captured with its table read on acceptance; the execute state registers
// the result strobe and payload. Busy, which blocks new commands, stays high for the cycle
// in which the step table's registered read data is used. The receiver cannot stall results.
// Reset (arst_n low, asynchronous): count, playback state and output level clear to
// zero; table contents are undefined until written and entries past the count read 0.
module pulse_sequence_generator_unit #(
	parameter int unsigned DEPTH = psg_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [psg_pkg::CMD_W-1:0]     command,
	input  logic                          step_level,
	input  logic [psg_pkg::TICKS_W-1:0]   step_ticks,
	input  logic [psg_pkg::IDX_W-1:0]     entry_index,
	input  logic                          pin_now,
	output logic                          valid,
	output logic                          pin_out,
	output logic                          running,
	output logic                          done_res,
	output logic [psg_pkg::LEN_W-1:0]     length,
	output logic                          rejected,
	output logic                          read_valid,
	output logic                          read_level,
	output logic [psg_pkg::TICKS_W-1:0]   read_ticks
);
	import psg_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;

	// Command beat captured on acceptance
	logic [CMD_W-1:0]   cmd_s1;
	logic               level_s1;
	logic [TICKS_W-1:0] ticks_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               pin_s1;

	// Playback state
	logic [CW-1:0]      step_count_q;
	logic [CW-1:0]      next_step_q;
	logic [TICKS_W-1:0] ticks_left_q;
	logic               saved_q;
	logic               drive_q;
	logic               run_q;

	// Result registers
	logic               valid_q;
	logic               done_q;
	logic               rej_q;
	logic               rv_q;
	logic               rl_q;
	logic [TICKS_W-1:0] rt_q;

	// Next-state values
	logic [CW-1:0]      nxt_count;
	logic [CW-1:0]      nxt_next;
	logic [TICKS_W-1:0] nxt_tl;
	logic               nxt_saved;
	logic               nxt_drive;
	logic               nxt_run;
	logic               nxt_done;
	logic               nxt_rej;
	logic               nxt_rv;
	logic               nxt_rl;
	logic [TICKS_W-1:0] nxt_rt;

	// Table port signals
	logic               accept;
	logic               tbl_we;
	logic [AW-1:0]      tbl_raddr;
	psg_entry_t         tbl_wdata;
	psg_entry_t         tbl_rdata;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Read address issued with the command beat: read index, next step or first step
	always_comb begin
		case (command)
			CMD_READ: tbl_raddr = entry_index[AW-1:0];
			CMD_TICK: tbl_raddr = next_step_q[AW-1:0];
			default:  tbl_raddr = '0;
		endcase
	end

	assign tbl_wdata.level = level_s1;
	assign tbl_wdata.ticks = ticks_s1;

	psg_table #(
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(step_count_q[AW-1:0]),
		.wdata(tbl_wdata),
		.re   (accept),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata)
	);

	// Command execution on the registered read data
	always_comb begin
		nxt_count = step_count_q;
		nxt_next  = next_step_q;
		nxt_tl    = ticks_left_q;
		nxt_saved = saved_q;
		nxt_drive = drive_q;
		nxt_run   = run_q;
		nxt_done  = 1'b0;
		nxt_rej   = 1'b0;
		nxt_rv    = 1'b0;
		nxt_rl    = 1'b0;
		nxt_rt    = '0;
		tbl_we    = 1'b0;
		if (state_q == ST_EXEC) begin
			if (run_q && (cmd_s1 != CMD_TICK)) begin
				nxt_rej = 1'b1;
			end else begin
				case (cmd_s1)
					CMD_CLEAR: begin
						nxt_count = '0;
					end
					CMD_ADD: begin
						if (step_count_q < CW'(DEPTH)) begin
							tbl_we    = 1'b1;
							nxt_count = step_count_q + 1'b1;
						end else begin
							nxt_rej = 1'b1;
						end
					end
					CMD_START: begin
						nxt_saved = pin_s1;
						if (step_count_q != '0) begin
							nxt_tl    = tbl_rdata.ticks;
							nxt_drive = tbl_rdata.level;
							nxt_next  = CW'(1);
							nxt_run   = 1'b1;
						end else begin
							// empty table: restore at once and finish
							nxt_drive = pin_s1;
							nxt_tl    = '0;
							nxt_next  = '0;
							nxt_run   = 1'b0;
							nxt_done  = 1'b1;
						end
					end
					CMD_TICK: begin
						if (run_q) begin
							if (ticks_left_q <= TICKS_W'(1)) begin
								if (next_step_q < step_count_q) begin
									nxt_tl    = tbl_rdata.ticks;
									nxt_drive = tbl_rdata.level;
									nxt_next  = next_step_q + 1'b1;
								end else begin
									nxt_drive = saved_q;
									nxt_tl    = '0;
									nxt_run   = 1'b0;
									nxt_done  = 1'b1;
								end
							end else begin
								nxt_tl = ticks_left_q - 1'b1;
							end
						end
					end
					CMD_READ: begin
						if (idx_s1 < IDX_W'(DEPTH)) begin
							nxt_rv = 1'b1;
							// entries past the count were cleared or never written
							if (idx_s1 < IDX_W'(step_count_q)) begin
								nxt_rl = tbl_rdata.level;
								nxt_rt = tbl_rdata.ticks;
							end
						end else begin
							nxt_rl = 1'b1;
							nxt_rt = '1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Command beat capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= command;
			level_s1 <= step_level;
			ticks_s1 <= step_ticks;
			idx_s1   <= entry_index;
			pin_s1   <= pin_now;
		end
	end

	// State machine, playback state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_count_q <= '0;
			next_step_q  <= '0;
			ticks_left_q <= '0;
			saved_q      <= 1'b0;
			drive_q      <= 1'b0;
			run_q        <= 1'b0;
			valid_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					valid_q <= 1'b0;
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					step_count_q <= nxt_count;
					next_step_q  <= nxt_next;
					ticks_left_q <= nxt_tl;
					saved_q      <= nxt_saved;
					drive_q      <= nxt_drive;
					run_q        <= nxt_run;
					valid_q      <= 1'b1;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			done_q <= nxt_done;
			rej_q  <= nxt_rej;
			rv_q   <= nxt_rv;
			rl_q   <= nxt_rl;
			rt_q   <= nxt_rt;
		end
	end

	assign valid      = valid_q;
	assign pin_out    = drive_q;
	assign running    = run_q;
	assign length     = LEN_W'(step_count_q);
	assign done_res   = done_q;
	assign rejected   = rej_q;
	assign read_valid = rv_q;
	assign read_level = rl_q;
	assign read_ticks = rt_q;

endmodule

// File: rtl/core/psg_checker.sv
module psg_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic valid,
	input logic done_res,
	input logic running,
	input logic rejected,
	input logic read_valid
);

	// A taken command occupies the block for the next cycle, with no beat yet
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !valid)
		else $error("command taken without busy cycle");

	// Busy lasts one cycle and is followed by the result beat
	a_busy_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> valid && !busy)
		else $error("busy not followed by result beat");

	// A finishing beat leaves playback stopped and is never a rejection
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid && done_res |-> !running && !rejected)
		else $error("done with playback still running or rejected");

	// A read result is never a rejected or finishing beat
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid && read_valid |-> !rejected && !done_res && !running)
		else $error("read beat carries other status");

endmodule

bind pulse_sequence_generator_unit psg_checker u_psg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.valid     (valid),
	.done_res  (done_res),
	.running   (running),
	.rejected  (rejected),
	.read_valid(read_valid)
);
